/* rtl/bbpg_pkg.sv */
// ----------------------------------------------------------------------------
// bbpg_pkg
// shared types, constants and the rounding helper of the bezier grid evaluator
// ----------------------------------------------------------------------------
package bbpg_pkg;

    localparam int MemDepth = 4096;
    localparam int AddrW    = $clog2(MemDepth);
    localparam int CoordW   = 32;
    localparam int ParW     = 17;
    localparam int DimW     = 7;
    localparam int PatW     = 5;
    localparam int WtW      = 20;
    localparam int AccW     = 56;
    localparam int ProdW    = CoordW + WtW;

    localparam logic [ParW-1:0] One    = 17'd65536;
    localparam logic [DimW-1:0] MinDim = 7'd4;
    localparam logic [DimW-1:0] MaxDim = 7'd64;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_POS   = 2'd1;
    localparam logic [1:0] FUNC_DU    = 2'd2;
    localparam logic [1:0] FUNC_DV    = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [WtW-1:0] t_wt;
    typedef t_wt [3:0] t_wt4;

    typedef struct packed {
        logic                     valid;
        logic signed [CoordW-1:0] z;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] x;
    } t_pt;

    typedef struct packed {
        logic [1:0]      func;
        logic [DimW-1:0] w;
        logic [PatW-1:0] pat_u;
        logic [PatW-1:0] pat_v;
        logic [PatW-1:0] pu;
        logic [PatW-1:0] pv;
        t_wt4            wu;
        t_wt4            wv;
    } t_setup;

    // round to nearest, halves away from zero, by 16 bits
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] m;
        begin
            m = 64'sd0;
            if (x >= 64'sd0) begin
                rnd16 = (x + 64'sd32768) >>> 16;
            end else begin
                m = (-x + 64'sd32768) >>> 16;
                rnd16 = -m;
            end
        end
    endfunction

endpackage

/* rtl/bbpg_ram.sv */
// ----------------------------------------------------------------------------
// bbpg_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bbpg_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bbpg_setup.sv */
// ----------------------------------------------------------------------------
// bbpg_setup
// patch selection and bernstein weights, five register stages
// ----------------------------------------------------------------------------
module bbpg_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_func,
    input  logic [bbpg_pkg::ParW-1:0]     i_u,
    input  logic [bbpg_pkg::ParW-1:0]     i_v,
    input  logic [bbpg_pkg::DimW-1:0]     i_gw,
    input  logic [bbpg_pkg::DimW-1:0]     i_gh,
    output logic                          o_done,
    output bbpg_pkg::t_setup              o_setup
);
    import bbpg_pkg::*;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
        begin
            if (d < MinDim) begin
                clamp_dim = MinDim;
            end else if (d > MaxDim) begin
                clamp_dim = MaxDim;
            end else begin
                clamp_dim = d;
            end
        end
    endfunction

    // (d-1)/3 via multiply by 43/128, exact for d up to 64
    function automatic logic [PatW-1:0] patches(input logic [DimW-1:0] d);
        logic [11:0] m;
        begin
            m = 12'(d - 7'd1) * 12'd43;
            patches = m[11:7];
        end
    endfunction

    function automatic t_wt4 basis(input logic [ParW-1:0] t, input logic [ParW-1:0] s,
                                   input logic [33:0] ss, input logic [33:0] ts,
                                   input logic [33:0] tt, input logic deriv);
        logic [63:0]        a0, a1, a2, a3;
        logic signed [63:0] qss, qts, qtt, d0, d1, d2, d3;
        begin
            a0 = (64'(ss) * 64'(s) + 64'd2147483648) >> 32;
            a1 = (64'(ss) * 64'(t) * 64'd3 + 64'd2147483648) >> 32;
            a2 = (64'(tt) * 64'(s) * 64'd3 + 64'd2147483648) >> 32;
            a3 = (64'(tt) * 64'(t) + 64'd2147483648) >> 32;
            qss = $signed(64'(ss));
            qts = $signed(64'(ts));
            qtt = $signed(64'(tt));
            d0 = rnd16(-(qss * 64'sd3));
            d1 = rnd16(qss * 64'sd3 - qts * 64'sd6);
            d2 = rnd16(qts * 64'sd6 - qtt * 64'sd3);
            d3 = rnd16(qtt * 64'sd3);
            if (deriv) begin
                basis[0] = d0[WtW-1:0];
                basis[1] = d1[WtW-1:0];
                basis[2] = d2[WtW-1:0];
                basis[3] = d3[WtW-1:0];
            end else begin
                basis[0] = a0[WtW-1:0];
                basis[1] = a1[WtW-1:0];
                basis[2] = a2[WtW-1:0];
                basis[3] = a3[WtW-1:0];
            end
        end
    endfunction

    logic [4:0]       r_vld;
    logic [1:0]       r_func;
    logic [DimW-1:0]  r_w;
    logic [PatW-1:0]  r_pat_u, r_pat_v;
    logic [ParW-1:0]  r_cu, r_cv;
    logic [21:0]      r_su, r_sv;
    logic [PatW-1:0]  r_pu, r_pv;
    logic [ParW-1:0]  r_tu, r_tv, r_s_u, r_s_v;
    logic [33:0]      r_ssu, r_tsu, r_ttu, r_ssv, r_tsv, r_ttv;
    logic [ParW-1:0]  r_tu2, r_tv2, r_s_u2, r_s_v2;
    t_wt4             r_wu, r_wv;
    logic [PatW-1:0]  n_pu, n_pv;
    logic [21:0]      n_tu, n_tv;

    always_comb begin
        n_pu = (r_su[21:16] > 6'(r_pat_u - 5'd1)) ? (r_pat_u - 5'd1) : r_su[20:16];
        n_pv = (r_sv[21:16] > 6'(r_pat_v - 5'd1)) ? (r_pat_v - 5'd1) : r_sv[20:16];
        n_tu = r_su - {1'b0, n_pu, 16'd0};
        n_tv = r_sv - {1'b0, n_pv, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_func  <= i_func;
            r_w     <= clamp_dim(i_gw);
            r_pat_u <= patches(clamp_dim(i_gw));
            r_pat_v <= patches(clamp_dim(i_gh));
            r_cu    <= (i_u > One) ? One : i_u;
            r_cv    <= (i_v > One) ? One : i_v;
        end
        if (r_vld[0]) begin
            r_su <= 22'(r_cu) * 22'(r_pat_u);
            r_sv <= 22'(r_cv) * 22'(r_pat_v);
        end
        if (r_vld[1]) begin
            r_pu  <= n_pu;
            r_pv  <= n_pv;
            r_tu  <= n_tu[ParW-1:0];
            r_tv  <= n_tv[ParW-1:0];
            r_s_u <= One - n_tu[ParW-1:0];
            r_s_v <= One - n_tv[ParW-1:0];
        end
        if (r_vld[2]) begin
            r_ssu  <= 34'(r_s_u) * 34'(r_s_u);
            r_tsu  <= 34'(r_tu) * 34'(r_s_u);
            r_ttu  <= 34'(r_tu) * 34'(r_tu);
            r_ssv  <= 34'(r_s_v) * 34'(r_s_v);
            r_tsv  <= 34'(r_tv) * 34'(r_s_v);
            r_ttv  <= 34'(r_tv) * 34'(r_tv);
            r_tu2  <= r_tu;
            r_tv2  <= r_tv;
            r_s_u2 <= r_s_u;
            r_s_v2 <= r_s_v;
        end
        if (r_vld[3]) begin
            r_wu <= basis(r_tu2, r_s_u2, r_ssu, r_tsu, r_ttu, r_func == FUNC_DU);
            r_wv <= basis(r_tv2, r_s_v2, r_ssv, r_tsv, r_ttv, r_func == FUNC_DV);
        end
    end

    assign o_done = r_vld[4];

    always_comb begin
        o_setup.func  = r_func;
        o_setup.w     = r_w;
        o_setup.pat_u = r_pat_u;
        o_setup.pat_v = r_pat_v;
        o_setup.pu    = r_pu;
        o_setup.pv    = r_pv;
        o_setup.wu    = r_wu;
        o_setup.wv    = r_wv;
    end

endmodule

/* rtl/bicubic_bezier_patch_grid_eval.sv */
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_grid_eval
// piecewise bicubic bezier surface evaluation over a stored control grid
//
//  channel  dir  handshake                 contents
//  s_*      in   s_tvalid / s_tready       write point or evaluate request
//  m_*      out  m_tvalid / m_tready       position or scaled derivative
//  apb      in   psel, penable, pready     grid_width, grid_height
//
// a write transfer is taken in the idle state; an evaluation keeps s_tready low
// through 5 setup stages, a hand-off to the run state, 16 point reads from the
// single grid ram read port, the registered read, multiply and accumulate,
// then a scale and a round step, until its result enters the output register.
// after reset a clearing pass over all 4096 entries empties the grid; s_tready
// stays low until it ends. a finished result waits in the output register.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_grid_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // u_coord, v_coord, point_index, point_present,
                                   // point_x, point_y, point_z, pad
    input  logic [1:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // out_x, out_y, out_z
    output logic [2:0]   m_tuser,  // result_kind, saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import bbpg_pkg::*;

    typedef enum logic [6:0] {
        ST_CLR   = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_RUN   = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = rnd16(v);
            if (r > 64'sd2147483647) begin
                sat32 = {1'b1, 32'h7FFF_FFFF};
            end else if (r < -64'sd2147483648) begin
                sat32 = {1'b1, 32'h8000_0000};
            end else begin
                sat32 = {1'b0, r[31:0]};
            end
        end
    endfunction

    t_state              r_state, n_state;
    logic [AddrW:0]      r_clr;
    logic [DimW-1:0]     r_gw, r_gh;
    logic [3:0]          r_k;
    logic                r_rd_v, r_pr_v;
    t_wt                 r_wt;
    logic signed [ProdW-1:0] r_px, r_py, r_pz;
    logic signed [AccW-1:0]  r_ax, r_ay, r_az;
    logic signed [63:0]  r_sx, r_sy, r_sz;
    logic                r_m_valid;
    logic [95:0]         r_m_data;
    logic [2:0]          r_m_user;

    logic                accept, cfg_wr, setup_done, out_free;
    t_setup              setup;
    logic                ram_we;
    logic [AddrW-1:0]    ram_waddr, ram_raddr;
    t_pt                 ram_wdata, ram_rdata;
    logic [6:0]          row, col;
    logic [13:0]         addr_full;
    logic signed [63:0]  wt_full;
    logic [PatW-1:0]     scale;
    logic [32:0]         fx, fy, fz;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_free = !r_m_valid || m_tready;

    always_comb begin
        prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_gh) : 32'(r_gw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 7'd4;
            r_gh <= 7'd4;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                r_gh <= pwdata[DimW-1:0];
            end else begin
                r_gw <= pwdata[DimW-1:0];
            end
        end
    end

    // grid write port: clearing pass or point write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = s_tdata[45:34];
        ram_wdata.valid = s_tdata[46];
        ram_wdata.x     = s_tdata[78:47];
        ram_wdata.y     = s_tdata[110:79];
        ram_wdata.z     = s_tdata[142:111];
        if (r_state == ST_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr[AddrW-1:0];
            ram_wdata = '0;
        end else if (accept && s_tuser == FUNC_WRITE) begin
            ram_we = 1'b1;
        end
    end

    bbpg_ram #(.W($bits(t_pt)), .D(MemDepth)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bbpg_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && s_tuser != FUNC_WRITE),
        .i_func  (s_tuser),
        .i_u     (s_tdata[16:0]),
        .i_v     (s_tdata[33:17]),
        .i_gw    (r_gw),
        .i_gh    (r_gh),
        .o_done  (setup_done),
        .o_setup (setup)
    );

    // point address and weight of step r_k
    always_comb begin
        row       = 7'(setup.pv) * 7'd3 + 7'(r_k[3:2]);
        col       = 7'(setup.pu) * 7'd3 + 7'(r_k[1:0]);
        addr_full = 14'(row) * 14'(setup.w) + 14'(col);
        ram_raddr = addr_full[AddrW-1:0];
        wt_full   = rnd16(64'($signed(setup.wu[r_k[1:0]]))
                        * 64'($signed(setup.wv[r_k[3:2]])));
    end

    always_comb begin
        case (setup.func)
            FUNC_DU: scale = setup.pat_u;
            FUNC_DV: scale = setup.pat_v;
            default: scale = 5'd1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:   if (r_clr == (AddrW+1)'(MemDepth - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && s_tuser != FUNC_WRITE) n_state = ST_SETUP;
            ST_SETUP: if (setup_done) n_state = ST_RUN;
            ST_RUN:   if (r_k == 4'd15) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_rd_v && !r_pr_v) n_state = ST_MUL;
            ST_MUL:   n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_k       <= '0;
            r_rd_v    <= 1'b0;
            r_pr_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_RUN) begin
                r_k <= r_k + 4'd1;
            end else begin
                r_k <= '0;
            end
            r_rd_v <= (r_state == ST_RUN);
            r_pr_v <= r_rd_v;
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // weighted point accumulation, derivative scaling and output capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            r_wt <= wt_full[WtW-1:0];
        end
        if (r_rd_v) begin
            r_px <= ram_rdata.valid ? ProdW'(ram_rdata.x) * ProdW'(r_wt) : '0;
            r_py <= ram_rdata.valid ? ProdW'(ram_rdata.y) * ProdW'(r_wt) : '0;
            r_pz <= ram_rdata.valid ? ProdW'(ram_rdata.z) * ProdW'(r_wt) : '0;
        end
        if (r_state == ST_SETUP) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= '0;
        end else if (r_pr_v) begin
            r_ax <= r_ax + AccW'(r_px);
            r_ay <= r_ay + AccW'(r_py);
            r_az <= r_az + AccW'(r_pz);
        end
        if (r_state == ST_MUL) begin
            r_sx <= 64'(r_ax) * $signed({59'd0, scale});
            r_sy <= 64'(r_ay) * $signed({59'd0, scale});
            r_sz <= 64'(r_az) * $signed({59'd0, scale});
        end
        if (r_state == ST_OUT && out_free) begin
            r_m_data <= {fz[31:0], fy[31:0], fx[31:0]};
            r_m_user <= {fx[32] | fy[32] | fz[32], setup.func - 2'd1};
        end
    end

    always_comb begin
        fx = sat32(r_sx);
        fy = sat32(r_sy);
        fz = sat32(r_sz);
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

endmodule

/* test/bicubic_bezier_patch_grid_eval_tb.sv */
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_grid_eval_tb
// self-checking bench for the bezier grid evaluator: a directed table, then
// random point writes and evaluations under several grid sizes, with random
// idling on both streams and one long output stall. every result is compared
// field by field with a predictor in the bench or, for typed rows, the table.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_grid_eval_tb;
    import bbpg_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  kind;
        logic        sat;
    } t_surf;

    typedef struct {
        logic [1:0]  func;
        logic [16:0] u;
        logic [16:0] v;
        logic [11:0] idx;
        logic        pres;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          typed;
        t_surf       res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    bicubic_bezier_patch_grid_eval dut (.*);

    // predictor state
    logic signed [31:0] grid_x [MemDepth];
    logic signed [31:0] grid_y [MemDepth];
    logic signed [31:0] grid_z [MemDepth];
    bit                 grid_present [MemDepth];
    logic [6:0]         reg_width;
    logic [6:0]         reg_height;

    t_surf pending_results[$];
    int    errors;
    int    cycles;
    int    hold_left;
    int    rx_gap;
    int    rx_idle_pct;
    int    tx_idle_pct;
    bit    quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic longint rnd_shift(input longint a, input int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (a >= 0)
            return (a + half) >>> n;
        return -((-a + half) >>> n);
    endfunction

    function automatic longint clamp_dim(input logic [6:0] d);
        if (d < 4)
            return 4;
        if (d > 64)
            return 64;
        return longint'(d);
    endfunction

    function automatic void bernstein(input longint t, input bit deriv, output longint wt[4]);
        longint s;
        s = 65536 - t;
        if (!deriv) begin
            wt[0] = rnd_shift(s * s * s, 32);
            wt[1] = rnd_shift(3 * t * s * s, 32);
            wt[2] = rnd_shift(3 * t * t * s, 32);
            wt[3] = rnd_shift(t * t * t, 32);
        end else begin
            wt[0] = rnd_shift(-3 * s * s, 16);
            wt[1] = rnd_shift(3 * s * s - 6 * t * s, 16);
            wt[2] = rnd_shift(6 * t * s - 3 * t * t, 16);
            wt[3] = rnd_shift(3 * t * t, 16);
        end
    endfunction

    function automatic logic [31:0] sat32(input longint acc, input longint scale,
                                          inout logic sat);
        longint r;
        r = rnd_shift(acc * scale, 16);
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            sat = 1'b1;
        end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            sat = 1'b1;
        end
        return r[31:0];
    endfunction

    function automatic t_surf eval_surface(input logic [1:0] func, input logic [16:0] u,
                                           input logic [16:0] v);
        t_surf  r;
        longint w, h, pat_u, pat_v, pu, pv, lu, lv, cu, cv, idx, wt, scale;
        longint wu[4], wv[4];
        longint ax, ay, az;
        w = clamp_dim(reg_width);
        h = clamp_dim(reg_height);
        pat_u = (w - 1) / 3;
        pat_v = (h - 1) / 3;
        cu = (u > 65536) ? 65536 : longint'(u);
        cv = (v > 65536) ? 65536 : longint'(v);
        pu = (cu * pat_u) >>> 16;
        if (pu > pat_u - 1)
            pu = pat_u - 1;
        lu = cu * pat_u - pu * 65536;
        pv = (cv * pat_v) >>> 16;
        if (pv > pat_v - 1)
            pv = pat_v - 1;
        lv = cv * pat_v - pv * 65536;
        bernstein(lu, func == FUNC_DU, wu);
        bernstein(lv, func == FUNC_DV, wv);
        ax = 0;
        ay = 0;
        az = 0;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
                idx = (pv * 3 + j) * w + (pu * 3 + i);
                if (idx >= 0 && idx < MemDepth && grid_present[idx]) begin
                    wt = rnd_shift(wu[i] * wv[j], 16);
                    ax += longint'(grid_x[idx]) * wt;
                    ay += longint'(grid_y[idx]) * wt;
                    az += longint'(grid_z[idx]) * wt;
                end
            end
        end
        scale = (func == FUNC_DU) ? pat_u : (func == FUNC_DV) ? pat_v : 1;
        r.sat = 1'b0;
        r.x = sat32(ax, scale, r.sat);
        r.y = sat32(ay, scale, r.sat);
        r.z = sat32(az, scale, r.sat);
        r.kind = func - 2'd1;
        return r;
    endfunction

    // output side: random stalls plus one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap = $urandom_range(0, 15);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        t_surf want;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result transfer", m_tdata[31:0], 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[31:0] !== want.x)
                        report("out_x", m_tdata[31:0], want.x);
                    if (m_tdata[63:32] !== want.y)
                        report("out_y", m_tdata[63:32], want.y);
                    if (m_tdata[95:64] !== want.z)
                        report("out_z", m_tdata[95:64], want.z);
                    if (m_tuser[1:0] !== want.kind)
                        report("result_kind", 32'(m_tuser[1:0]), 32'(want.kind));
                    if (m_tuser[2] !== want.sat)
                        report("saturated", 32'(m_tuser[2]), 32'(want.sat));
                end
            end
        end
    end

    task automatic send_item(input t_row r);
        int gap;
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.func;
        s_tdata  = {1'b0, r.pz, r.py, r.px, r.pres, r.idx, r.v, r.u};
        do
            @(posedge i_clk);
        while (!s_tready);
        if (r.func == FUNC_WRITE) begin
            grid_present[r.idx] = r.pres;
            grid_x[r.idx] = r.px;
            grid_y[r.idx] = r.py;
            grid_z[r.idx] = r.pz;
        end else if (r.typed) begin
            pending_results = {pending_results, r.res};
        end else begin
            pending_results = {pending_results, eval_surface(r.func, r.u, r.v)};
        end
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic reg_write(input logic addr_bit, input logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {addr_bit, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b1;
        @(negedge i_clk);
        pwrite  = 1'b0;
        psel    = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[6:0] !== val[6:0])
            report("register readback", prdata, val & 32'h7f);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr_bit == REG_WIDTH)
            reg_width = val[6:0];
        else
            reg_height = val[6:0];
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return $urandom_range(0, 32'h1fffff) - 32'h100000;
        if (k < 8)
            return $urandom;
        return (k == 8) ? 32'h7fffffff : 32'h80000000;
    endfunction

    function automatic logic [16:0] rand_param();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 17'd0;
        if (k == 1)
            return One;
        if (k == 2)
            return $urandom_range(65537, 131071);
        return $urandom_range(0, 65536);
    endfunction

    function automatic t_row rand_item();
        t_row   r;
        longint span;
        r.typed = 1'b0;
        r.res   = '{default: '0};
        r.func  = ($urandom_range(0, 99) < 35) ? FUNC_WRITE : 2'($urandom_range(1, 3));
        span    = clamp_dim(reg_width) * clamp_dim(reg_height);
        r.idx   = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, int'(span) - 1))
                                                : 12'($urandom);
        r.pres  = $urandom_range(0, 99) < 85;
        r.px    = rand_coord();
        r.py    = rand_coord();
        r.pz    = rand_coord();
        r.u     = rand_param();
        r.v     = rand_param();
        return r;
    endfunction

    t_row directed [] = '{
        '{FUNC_POS, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_DU, 17'd65536, 17'd65536, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 2'd1, 1'b0}},
        '{FUNC_DV, 17'd131071, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 2'd2, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd0, 1'b1, 32'h00010000, 32'hffff0000, 32'd0,
          1'b0, '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_POS, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'h00010000, 32'hffff0000, 32'd0, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd0, 1'b1, 32'h7fffffff, 32'h80000000, 32'd1,
          1'b0, '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_DU, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'h80000000, 32'h7fffffff, 32'hfffffffd, 2'd1, 1'b1}},
        '{FUNC_POS, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'h7fffffff, 32'h80000000, 32'd1, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd15, 1'b1, 32'hffffffff, 32'h00123456,
          32'hfedcba98, 1'b0, '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_POS, 17'd65536, 17'd65536, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd4095, 1'b1, 32'h55555555, 32'haaaaaaaa,
          32'h0000ffff, 1'b0, '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd5, 1'b0, 32'h12345678, 32'h1, 32'h2, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd6, 1'b1, 32'h00030000, 32'hfffd0000,
          32'h00008000, 1'b0, '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_POS, 17'd32768, 17'd32768, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_DV, 17'd12345, 17'd54321, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_DU, 17'd99999, 17'd1, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_WRITE, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}},
        '{FUNC_POS, 17'd0, 17'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 2'd0, 1'b0}}
    };

    // grid sizes per phase, out-of-range values included
    logic [6:0] phase_w [7] = '{7'd7, 7'd64, 7'd13, 7'd0, 7'd127, 7'd4, 7'd40};
    logic [6:0] phase_h [7] = '{7'd7, 7'd64, 7'd22, 7'd127, 7'd1, 7'd4, 7'd10};

    initial begin
        errors      = 0;
        cycles      = 0;
        hold_left   = 0;
        rx_gap      = 0;
        rx_idle_pct = 10;
        tx_idle_pct = 15;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_WRITE;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        reg_width   = 7'd4;
        reg_height  = 7'd4;
        for (int i = 0; i < MemDepth; i++) begin
            grid_present[i] = 1'b0;
            grid_x[i] = '0;
            grid_y[i] = '0;
            grid_z[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k])
            send_item(directed[k]);

        for (int p = 0; p < 7; p++) begin
            drain();
            reg_write(REG_WIDTH, {25'd0, phase_w[p]});
            reg_write(REG_HEIGHT, {25'd0, phase_h[p]});
            rx_idle_pct = (p == 2) ? 0 : 5 + 5 * (p % 3);
            tx_idle_pct = (p == 2) ? 0 : 10 + 5 * (p % 2);
            if (p == 1)
                hold_left = 3000;
            if (p == 6)
                quiet = 1'b1;
            for (int n = 0; n < 190; n++)
                send_item(rand_item());
        end

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
